>>> rtl/sorted_list_merger_assert.svh
// ---------------------------------------------------------------------------
// sorted_list_merger assertion macros
// shared property forms for the merger's concurrent checks
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_MERGER_ASSERT_SVH
`define SORTED_LIST_MERGER_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define SLM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define SLM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/slm_pkg.sv
// ---------------------------------------------------------------------------
// slm_pkg
// types and constants shared by the sorted list merger
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package slm_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VAL_W         = 32;

    // list select codes on the load channel
    localparam logic CMD_LIST_A = 1'b0;
    localparam logic CMD_LIST_B = 1'b1;

    // merge order register codes
    localparam logic ORDER_ASC  = 1'b0;
    localparam logic ORDER_DESC = 1'b1;

    typedef logic signed [VAL_W-1:0] value_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_PRIME,
        ST_MERGE
    } slm_state_t;

endpackage

`default_nettype wire

>>> rtl/slm_if.sv
// ---------------------------------------------------------------------------
// slm channel interfaces
// valid/ready channels for load words, merged words and the order register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface slm_load_if;
    logic                valid;
    logic                ready;
    logic                cmd;
    slm_pkg::value_t     value;
    logic                last;

    modport source (output valid, output cmd, output value, output last, input ready);
    modport sink   (input valid, input cmd, input value, input last, output ready);
endinterface

interface slm_merged_if;
    logic                valid;
    logic                ready;
    slm_pkg::value_t     merged_value;
    logic                final_res;

    modport source (output valid, output merged_value, output final_res, input ready);
    modport sink   (input valid, input merged_value, input final_res, output ready);
endinterface

interface slm_cfg_if;
    logic                valid;
    logic                ready;
    logic                order;

    modport source (output valid, output order, input ready);
    modport sink   (input valid, input order, output ready);
endinterface

`default_nettype wire

>>> rtl/slm_list_mem.sv
// ---------------------------------------------------------------------------
// slm_list_mem
// one list store: single write port, registered read port
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module slm_list_mem #(
    parameter int DEPTH  = slm_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire slm_pkg::value_t   wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output      slm_pkg::value_t   rd_data
);

    slm_pkg::value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns the old word on a same-address write
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/sorted_list_merger.sv
// ---------------------------------------------------------------------------
// sorted_list_merger
// two-way merge of two pre-sorted lists of signed Q16.16 values
// ---------------------------------------------------------------------------
// usage:
//   load   - sink channel; each word carries cmd (0 list A, 1 list B), value
//            and last. last closes the selected list. words past DEPTH in a
//            list are dropped (their last still closes it); words for a list
//            already closed are ignored
//   merged - source channel; after both lists are closed the block sends
//            count_a + count_b words in merge order, final_res on the last
//   cfg    - order register write (0 ascending, 1 descending); always ready,
//            write only while the block is idle
// timing:
//   load takes each offered word at once in the load state; after the closing
//   word a prime state re-reads the store heads, then one merged word per cycle
//   while the receiver takes it. the merge step is bound by the registered read
//   of each list store. load stays low from the closing word until the final
//   merged word enters the output register
// reset: counts, closed flags, order and output valid clear; stores are not
//   cleared. a stalled receiver holds the output register and the merge waits
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_list_merger_assert.svh"

module sorted_list_merger #(
    parameter int DEPTH = slm_pkg::DEPTH_DEFAULT
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    slm_load_if.sink    load,
    slm_merged_if.source merged,
    slm_cfg_if.sink     cfg
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // control state
    slm_pkg::slm_state_t state_reg, state_next;
    logic [CNT_W-1:0]    count_a_reg, count_a_next;
    logic [CNT_W-1:0]    count_b_reg, count_b_next;
    logic                closed_a_reg, closed_a_next;
    logic                closed_b_reg, closed_b_next;
    logic [CNT_W-1:0]    idx_a_reg, idx_a_next;
    logic [CNT_W-1:0]    idx_b_reg, idx_b_next;
    logic                order_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    slm_pkg::value_t     out_value_reg, out_value_next;
    logic                out_final_reg, out_final_next;

    // store ports
    logic                wr_a_en, wr_b_en;
    logic [ADDR_W-1:0]   rd_addr_a, rd_addr_b;
    slm_pkg::value_t     head_a, head_b;

    // merge step
    logic                out_free;
    logic                a_avail, b_avail, a_first, pop_a, last_pop, emit;
    logic [CNT_W-1:0]    idx_a_adv, idx_b_adv;

    assign load.ready   = (state_reg == slm_pkg::ST_LOAD);
    assign cfg.ready    = 1'b1;
    assign merged.valid        = out_valid_reg;
    assign merged.merged_value = out_value_reg;
    assign merged.final_res    = out_final_reg;

    // the output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || merged.ready;

    // heads of the lists are valid in the merge state (primed in the prime state)
    assign a_avail = (idx_a_reg < count_a_reg);
    assign b_avail = (idx_b_reg < count_b_reg);
    // strict precedence of A; ties go to B
    assign a_first = (order_reg == slm_pkg::ORDER_DESC) ? (head_b < head_a)
                                                        : (head_a < head_b);
    assign pop_a     = a_avail && (!b_avail || a_first);
    assign idx_a_adv = idx_a_reg + CNT_W'(pop_a);
    assign idx_b_adv = idx_b_reg + CNT_W'(!pop_a);
    assign last_pop  = (idx_a_adv == count_a_reg) && (idx_b_adv == count_b_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_a_next   = count_a_reg;
        count_b_next   = count_b_reg;
        closed_a_next  = closed_a_reg;
        closed_b_next  = closed_b_reg;
        idx_a_next     = idx_a_reg;
        idx_b_next     = idx_b_reg;
        wr_a_en        = 1'b0;
        wr_b_en        = 1'b0;
        emit           = 1'b0;
        out_valid_next = out_valid_reg && !merged.ready;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;

        unique case (state_reg)
            slm_pkg::ST_LOAD:
            begin
                if (load.valid)
                begin
                    // words for a closed list fall through untouched
                    if (load.cmd == slm_pkg::CMD_LIST_A && !closed_a_reg)
                    begin
                        if (count_a_reg < DEPTH_CNT)
                        begin
                            wr_a_en      = 1'b1;
                            count_a_next = count_a_reg + CNT_W'(1);
                        end
                        if (load.last)
                        begin
                            closed_a_next = 1'b1;
                        end
                    end
                    else if (load.cmd == slm_pkg::CMD_LIST_B && !closed_b_reg)
                    begin
                        if (count_b_reg < DEPTH_CNT)
                        begin
                            wr_b_en      = 1'b1;
                            count_b_next = count_b_reg + CNT_W'(1);
                        end
                        if (load.last)
                        begin
                            closed_b_next = 1'b1;
                        end
                    end
                    if (closed_a_next && closed_b_next)
                    begin
                        state_next = slm_pkg::ST_PRIME;
                    end
                end
            end

            slm_pkg::ST_PRIME:
            begin
                // entry 0 may have been written on the closing edge: read again
                state_next = slm_pkg::ST_MERGE;
            end

            slm_pkg::ST_MERGE:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    out_valid_next = 1'b1;
                    out_value_next = pop_a ? head_a : head_b;
                    out_final_next = last_pop;
                    idx_a_next     = idx_a_adv;
                    idx_b_next     = idx_b_adv;
                    if (last_pop)
                    begin
                        state_next    = slm_pkg::ST_LOAD;
                        count_a_next  = '0;
                        count_b_next  = '0;
                        closed_a_next = 1'b0;
                        closed_b_next = 1'b0;
                        idx_a_next    = '0;
                        idx_b_next    = '0;
                    end
                end
            end

            default:
            begin
                state_next = slm_pkg::ST_LOAD;
            end
        endcase
    end

    // read address follows the next head index so the head is ready in the next cycle
    assign rd_addr_a = (idx_a_next < DEPTH_CNT) ? idx_a_next[ADDR_W-1:0] : '0;
    assign rd_addr_b = (idx_b_next < DEPTH_CNT) ? idx_b_next[ADDR_W-1:0] : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slm_pkg::ST_LOAD;
            count_a_reg   <= '0;
            count_b_reg   <= '0;
            closed_a_reg  <= 1'b0;
            closed_b_reg  <= 1'b0;
            idx_a_reg     <= '0;
            idx_b_reg     <= '0;
            order_reg     <= slm_pkg::ORDER_ASC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_a_reg   <= count_a_next;
            count_b_reg   <= count_b_next;
            closed_a_reg  <= closed_a_next;
            closed_b_reg  <= closed_b_next;
            idx_a_reg     <= idx_a_next;
            idx_b_reg     <= idx_b_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                order_reg <= cfg.order;
            end
        end
    end

    // payload of the output register
    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_final_reg <= out_final_next;
    end

    slm_list_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_list_a (
        .clk     (clk),
        .wr_en   (wr_a_en),
        .wr_addr (count_a_reg[ADDR_W-1:0]),
        .wr_data (load.value),
        .rd_addr (rd_addr_a),
        .rd_data (head_a)
    );

    slm_list_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_list_b (
        .clk     (clk),
        .wr_en   (wr_b_en),
        .wr_addr (count_b_reg[ADDR_W-1:0]),
        .wr_data (load.value),
        .rd_addr (rd_addr_b),
        .rd_data (head_b)
    );

    // read indexes never run past the loaded counts
    `SLM_ASSERT_NOW(a_idx_in_range, 1'b1, (idx_a_reg <= count_a_reg) && (idx_b_reg <= count_b_reg), "merge index past list count")

    // the loader never sits with both lists closed
    `SLM_ASSERT_NOW(a_load_not_closed, state_reg == slm_pkg::ST_LOAD, !(closed_a_reg && closed_b_reg), "both lists closed while loading")

    // the final merged word restarts loading with empty lists
    `SLM_ASSERT_NEXT(a_final_clears, emit && last_pop, (state_reg == slm_pkg::ST_LOAD) && (count_a_reg == '0) && (count_b_reg == '0) && merged.final_res, "final word did not clear lists")

endmodule

`default_nettype wire

>>> sim/sorted_list_merger_test.sv
// ---------------------------------------------------------------------------
// sorted_list_merger_test
// loads pairs of lists into the merger and checks every merged word and its
// final_res flag against an in-bench model of the merge. covers the value
// extremes, ties, full lists, words sent to closed lists, both merge orders,
// random sender gaps and receiver stalls
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_merger_test;

    import slm_pkg::*;

    localparam int LIST_DEPTH    = DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 20;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 18;

    typedef struct {
        logic   cmd;
        value_t value;
        logic   last;
    } load_word_t;

    typedef struct {
        value_t value;
        logic   final_res;
    } merged_word_t;

    // model of the merger: list contents, counts, close flags and order,
    // plus the merged words still to come out of the block
    class merge_tracker;
        value_t       list_a[LIST_DEPTH];
        value_t       list_b[LIST_DEPTH];
        int           count_a;
        int           count_b;
        bit           closed_a;
        bit           closed_b;
        logic         order;
        merged_word_t awaited[$];
        int           errors;

        function new();
            count_a  = 0;
            count_b  = 0;
            closed_a = 0;
            closed_b = 0;
            order    = ORDER_ASC;
            errors   = 0;
        endfunction

        task report(string what);
            errors++;
            if (errors <= 50)
                $display("mismatch: %s", what);
        endtask

        // head of A goes out only when it strictly precedes head of B
        function bit a_leads(value_t a, value_t b);
            if (order == ORDER_DESC)
                return b < a;
            return a < b;
        endfunction

        function void merge_lists();
            int i;
            int j;
            int total;
            merged_word_t w;
            i = 0;
            j = 0;
            total = count_a + count_b;
            while (i < count_a || j < count_b) begin
                if (i < count_a && j < count_b) begin
                    if (a_leads(list_a[i], list_b[j]))
                        w.value = list_a[i++];
                    else
                        w.value = list_b[j++];
                end else if (i < count_a) begin
                    w.value = list_a[i++];
                end else begin
                    w.value = list_b[j++];
                end
                w.final_res = (i + j == total);
                awaited.push_back(w);
            end
            count_a  = 0;
            count_b  = 0;
            closed_a = 0;
            closed_b = 0;
        endfunction

        function void take_load(load_word_t w);
            if (w.cmd == CMD_LIST_A) begin
                if (closed_a)
                    return;
                if (count_a < LIST_DEPTH)
                    list_a[count_a++] = w.value;
                if (w.last)
                    closed_a = 1;
            end else begin
                if (closed_b)
                    return;
                if (count_b < LIST_DEPTH)
                    list_b[count_b++] = w.value;
                if (w.last)
                    closed_b = 1;
            end
            if (closed_a && closed_b)
                merge_lists();
        endfunction

        task check_merged(value_t v, logic f);
            merged_word_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected merged word %h final_res %b", v, f));
                return;
            end
            want = awaited.pop_front();
            if (v !== want.value)
                report($sformatf("merged_value %h, expected %h", v, want.value));
            if (f !== want.final_res)
                report($sformatf("final_res %b, expected %b on value %h",
                                 f, want.final_res, want.value));
        endtask
    endclass

    logic clk;
    logic rst_n;

    slm_load_if   load_ch ();
    slm_merged_if merged_ch ();
    slm_cfg_if    cfg_ch ();

    sorted_list_merger #(
        .DEPTH  (LIST_DEPTH)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_ch),
        .merged (merged_ch),
        .cfg    (cfg_ch)
    );

    merge_tracker merges = new();

    load_word_t round_words[$];
    int         burst_left = 0;
    bit         gaps_on    = 1'b1;
    int         stim_items = 0;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------- driving

    function void add_word(logic cmd, value_t value, logic last);
        load_word_t w;
        w.cmd   = cmd;
        w.value = value;
        w.last  = last;
        round_words.push_back(w);
    endfunction

    // sender runs in bursts; a new burst may open with a gap
    task automatic send_word(load_word_t w);
        int gap;
        @(negedge clk);
        if (burst_left == 0) begin
            gap        = gaps_on ? $urandom_range(0, 4) : 0;
            burst_left = $urandom_range(1, 8);
            if (gap > 0) begin
                load_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        load_ch.valid <= 1'b1;
        load_ch.cmd   <= w.cmd;
        load_ch.value <= w.value;
        load_ch.last  <= w.last;
        do @(posedge clk); while (load_ch.ready !== 1'b1);
        merges.take_load(w);
    endtask

    task automatic send_round();
        while (round_words.size() != 0)
            send_word(round_words.pop_front());
    endtask

    // hold the sender until every merged word is back, then let the block settle
    task automatic drain();
        @(negedge clk);
        load_ch.valid <= 1'b0;
        burst_left = 0;
        while (merges.awaited.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_order(logic setting);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.order <= setting;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        merges.order = setting;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------- generation

    // mostly short lists, now and then one near or past the store depth
    function automatic int pick_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(LIST_DEPTH - 2, LIST_DEPTH + 4);
        return $urandom_range(1, 5);
    endfunction

    function automatic value_t pick_value(int flavor);
        int k;
        if (flavor == 6 || flavor == 7) begin
            // few distinct values so ties are common
            k = int'($urandom_range(0, 6)) - 3;
            return value_t'(k * 65536);
        end
        if (flavor == 8) begin
            case ($urandom_range(0, 4))
                0:       return value_t'(32'h8000_0000);
                1:       return value_t'(32'h7fff_ffff);
                2:       return value_t'(32'h0000_0000);
                3:       return value_t'(32'hffff_ffff);
                default: return value_t'(32'h0000_0001);
            endcase
        end
        return value_t'($urandom);
    endfunction

    // one pair of lists, randomly interleaved; flavor 9 leaves them unsorted.
    // once a list closes, a stray word may still be sent to it
    task automatic make_round();
        int     len_a;
        int     len_b;
        int     flavor;
        int     ia;
        int     ib;
        bit     take_a;
        value_t qa[$];
        value_t qb[$];
        len_a  = pick_len();
        len_b  = pick_len();
        flavor = $urandom_range(0, 9);
        for (int n = 0; n < len_a; n++)
            qa.push_back(pick_value(flavor));
        for (int n = 0; n < len_b; n++)
            qb.push_back(pick_value(flavor));
        if (flavor != 9) begin
            if (merges.order == ORDER_DESC) begin
                qa.rsort();
                qb.rsort();
            end else begin
                qa.sort();
                qb.sort();
            end
        end
        stim_items += len_a + len_b;
        ia = 0;
        ib = 0;
        while (ia < len_a || ib < len_b) begin
            take_a = (ib == len_b) || (ia < len_a && $urandom_range(0, 1) == 1);
            if (take_a) begin
                add_word(CMD_LIST_A, qa[ia], ia == len_a - 1);
                ia++;
                if (ia == len_a && ib < len_b && $urandom_range(0, 3) == 0)
                    add_word(CMD_LIST_A, value_t'($urandom), $urandom_range(0, 1) == 1);
            end else begin
                add_word(CMD_LIST_B, qb[ib], ib == len_b - 1);
                ib++;
                if (ib == len_b && ia < len_a && $urandom_range(0, 3) == 0)
                    add_word(CMD_LIST_B, value_t'($urandom), $urandom_range(0, 1) == 1);
            end
        end
    endtask

    // -------------------------------------------------------------- stimulus

    initial
    begin : stimulus
        int target;
        rst_n         <= 1'b0;
        load_ch.valid <= 1'b0;
        load_ch.cmd   <= CMD_LIST_A;
        load_ch.value <= '0;
        load_ch.last  <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.order  <= ORDER_ASC;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_order(ORDER_ASC);

        // extremes of the value range with a tie at zero, B goes first
        add_word(CMD_LIST_A, value_t'(32'h8000_0000), 1'b0);
        add_word(CMD_LIST_B, value_t'(32'h0000_0000), 1'b0);
        add_word(CMD_LIST_A, value_t'(32'h0000_0000), 1'b1);
        add_word(CMD_LIST_B, value_t'(32'h7fff_ffff), 1'b1);
        send_round();

        // single-entry lists; B closes first and then gets a stray word
        add_word(CMD_LIST_B, value_t'(32'hffff_ffff), 1'b1);
        add_word(CMD_LIST_B, value_t'(32'h0005_0000), 1'b1);
        add_word(CMD_LIST_A, value_t'(32'hffff_ffff), 1'b1);
        send_round();

        // list A overruns the store; the dropped closing word still closes it
        for (int n = 0; n <= LIST_DEPTH; n++)
            add_word(CMD_LIST_A, value_t'(n * 65536), n == LIST_DEPTH);
        add_word(CMD_LIST_B, value_t'(8 * 65536), 1'b1);
        send_round();

        // random phases, alternating order, some without sender gaps
        for (int p = 0; p < PHASES; p++) begin
            write_order((p % 2 == 0) ? ORDER_DESC : ORDER_ASC);
            gaps_on = (p % 3 != 1);
            target  = stim_items + PHASE_WORDS;
            while (stim_items < target) begin
                make_round();
                send_round();
                if ($urandom_range(0, 5) == 0)
                    drain();
            end
        end

        drain();
        repeat (END_CYCLES) @(negedge clk);
        if (merges.errors == 0 && merges.awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------ receiver and check

    // receiver switches between always ready, coin flips and a rotating mask
    initial
    begin : receiver
        int         mode;
        int         hold;
        logic [15:0] mask;
        mode = 0;
        hold = 0;
        mask = '1;
        merged_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            if (hold == 0) begin
                mode = $urandom_range(0, 3);
                mask = 16'($urandom) | 16'h0001;
                hold = $urandom_range(40, 300);
            end
            hold--;
            case (mode)
                0: merged_ch.ready <= 1'b1;
                1: merged_ch.ready <= ($urandom_range(0, 1) == 1);
                default:
                begin
                    merged_ch.ready <= mask[0];
                    mask = {mask[0], mask[15:1]};
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (merged_ch.valid === 1'b1 && merged_ch.ready === 1'b1)
            merges.check_merged(merged_ch.merged_value, merged_ch.final_res);
    end

    // ends the run when no word moves on any channel for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((load_ch.valid === 1'b1 && load_ch.ready === 1'b1) ||
                (merged_ch.valid === 1'b1 && merged_ch.ready === 1'b1) ||
                (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
                idle = 0;
            else
                idle++;
        end
        $display("status: fail");
        $finish;
    end

endmodule
